@@ rtl/sha1_hash_unit_defines.svh @@
// ----------------------------------------------------------------------------
// sha1_hash_unit_defines.svh
// Assertion macros shared by the SHA-1 hash unit.
// ----------------------------------------------------------------------------
`ifndef SHA1_HASH_UNIT_DEFINES_SVH
`define SHA1_HASH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define SHA1_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define SHA1_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sha1_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1_pkg
// Types, constants and round functions of the SHA-1 hash unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_pkg;

  localparam int CELL_COUNT   = 16;
  localparam int DIGEST_WORDS = 5;

  localparam logic [5:0] FILL_LAST      = 6'd63;
  localparam logic [5:0] FILL_LEN_LIMIT = 6'd55;
  localparam logic [5:0] LEN_FIRST      = 6'd56;
  localparam logic [6:0] ROUND_LAST     = 7'd79;
  localparam logic [6:0] ROUND_GRP1     = 7'd20;
  localparam logic [6:0] ROUND_GRP2     = 7'd40;
  localparam logic [6:0] ROUND_GRP3     = 7'd60;
  localparam logic [7:0] PAD_MARK       = 8'h80;

  typedef logic [31:0] word_t;

  localparam word_t INIT_H [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_GRP0 = 32'h5A827999;
  localparam word_t K_GRP1 = 32'h6ED9EBA1;
  localparam word_t K_GRP2 = 32'h8F1BBCDC;
  localparam word_t K_GRP3 = 32'hCA62C1D6;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_BYTE,
    CELL_WORD
  } cell_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD
  } hash_state_t;

  typedef enum logic {
    ACT_ABSORB = 1'b0,
    ACT_FINISH = 1'b1
  } action_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic [6:0] rnd;
  } round_ctrl_t;

  // Round constant for the group that holds round rnd.
  function automatic word_t round_k(input logic [6:0] rnd);
    word_t k;
    if (rnd < ROUND_GRP1) begin
      k = K_GRP0;
    end else if (rnd < ROUND_GRP2) begin
      k = K_GRP1;
    end else if (rnd < ROUND_GRP3) begin
      k = K_GRP2;
    end else begin
      k = K_GRP3;
    end
    return k;
  endfunction

  // Boolean function of round rnd: choose, parity, majority, parity.
  function automatic word_t round_f(input logic [6:0] rnd, input word_t b,
                                    input word_t c, input word_t d);
    word_t f;
    if (rnd < ROUND_GRP1) begin
      f = (b & c) | (~b & d);
    end else if (rnd < ROUND_GRP2) begin
      f = b ^ c ^ d;
    end else if (rnd < ROUND_GRP3) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sha1_cell.sv @@
// ----------------------------------------------------------------------------
// sha1_cell
// One 32-bit word of the block window. Takes a byte or a word from its
// neighbor, so a row of sixteen is both the block buffer and the schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_cell (
  input  wire                     clk,
  input  sha1_pkg::cell_mode_t    mode,
  input  sha1_pkg::word_t         nbr_word,
  output sha1_pkg::word_t         word
);
  import sha1_pkg::*;

  // Shift one byte in from the neighbor, or take its whole word
  always_ff @(posedge clk) begin
    unique case (mode)
      CELL_HOLD: word <= word;
      CELL_BYTE: word <= {word[23:0], nbr_word[31:24]};
      CELL_WORD: word <= nbr_word;
      default:   word <= word;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/sha1_round.sv @@
// ----------------------------------------------------------------------------
// sha1_round
// Working registers a..e and one SHA-1 round per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_round (
  input  wire                                               clk,
  input  sha1_pkg::round_ctrl_t                             ctrl,
  input  sha1_pkg::word_t [sha1_pkg::DIGEST_WORDS-1:0]      chain,
  input  sha1_pkg::word_t                                   w,
  output sha1_pkg::word_t [sha1_pkg::DIGEST_WORDS-1:0]      work
);
  import sha1_pkg::*;

  word_t t;

  // Round sum: rotl(a,5) + f + e + w + k
  always_comb begin
    t = {work[0][26:0], work[0][31:27]}
        + round_f(ctrl.rnd, work[1], work[2], work[3])
        + work[4] + w + round_k(ctrl.rnd);
  end

  // Load from the chain words, or advance one round
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= chain;
    end else if (ctrl.step) begin
      work[4] <= work[3];
      work[3] <= work[2];
      work[2] <= {work[1][1:0], work[1][31:2]};
      work[1] <= work[0];
      work[0] <= t;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1_emit.sv @@
// ----------------------------------------------------------------------------
// sha1_emit
// Digest output chain: holds five words and shifts one out per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_emit (
  input  wire                                               clk,
  input  wire                                               rst,
  input  wire                                               load,
  input  sha1_pkg::word_t [sha1_pkg::DIGEST_WORDS-1:0]      digest,
  input  wire                                               digest_ready,
  output logic                                              digest_valid,
  output logic [31:0]                                       digest_word,
  output logic [2:0]                                        word_index,
  output logic                                              last_word
);
  import sha1_pkg::*;

  localparam logic [2:0] IDX_LAST = 3'(DIGEST_WORDS - 1);

  word_t [DIGEST_WORDS-1:0] words;
  logic                     beat;

  assign beat        = digest_valid & digest_ready;
  assign digest_word = words[0];
  assign last_word   = (word_index == IDX_LAST);

  // Track the beat count and the valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
      word_index   <= '0;
    end else if (load) begin
      digest_valid <= 1'b1;
      word_index   <= '0;
    end else if (beat) begin
      digest_valid <= ~last_word;
      word_index   <= word_index + 3'd1;
    end
  end

  // Capture the digest, then advance the words toward the port
  always_ff @(posedge clk) begin
    if (load) begin
      words <= digest;
    end else if (beat) begin
      for (int i = 0; i < DIGEST_WORDS - 1; i++) begin
        words[i] <= words[i + 1];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/sha1_hash_unit.sv @@
// ----------------------------------------------------------------------------
// sha1_hash_unit
// SHA-1 over a byte stream: absorb bytes, finish to pad and emit the digest.
// ----------------------------------------------------------------------------
//
//   channel  signals                            beat carries
//   -------  ---------------------------------  -------------------------------
//   item     item_valid / item_ready            action, data_byte
//   digest   digest_valid / digest_ready        digest_word, word_index, last_word
//
// Every 64th absorbed byte starts a block: 80 rounds through the single round
// unit, then a fold into the chain words. A finish pads the block to its end,
// runs the rounds and the fold, and does one more block when fewer than nine
// bytes of room are left. The five digest beats drain from their own
// register chain while new bytes are absorbed. The block buffer needs no
// clearing pass at reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_hash_unit (
  input  wire          clk,
  input  wire          rst,
  input  wire          item_valid,
  output logic         item_ready,
  input  wire          action,
  input  wire  [7:0]   data_byte,
  output logic         digest_valid,
  input  wire          digest_ready,
  output logic [31:0]  digest_word,
  output logic [2:0]   word_index,
  output logic         last_word
);
  import sha1_pkg::*;

  `include "sha1_hash_unit_defines.svh"

  hash_state_t             state;
  hash_state_t             state_next;
  logic [5:0]              fill;
  logic [60:0]             msg_bytes;
  logic [6:0]              rnd;
  logic                    pad_first;
  logic                    len_here;
  logic                    padding;
  word_t [DIGEST_WORDS-1:0] chain;
  word_t [DIGEST_WORDS-1:0] work;
  word_t [DIGEST_WORDS-1:0] chain_sum;

  cell_mode_t              cell_mode;
  word_t                   win [CELL_COUNT];
  word_t                   nbr [CELL_COUNT];
  word_t                   feed;
  word_t                   new_w;
  logic [63:0]             len_shift;
  logic [7:0]              pad_byte;
  logic                    accept;
  logic                    emit_busy;
  logic                    emit_load;
  logic                    final_fold;
  round_ctrl_t             rctl;

  assign accept     = item_valid & item_ready;
  assign emit_busy  = digest_valid;
  assign final_fold = padding & len_here;

  // Next schedule word from the window taps
  assign new_w = {win[0][30:0] ^ win[2][30:0] ^ win[8][30:0] ^ win[13][30:0],
                  win[0][31] ^ win[2][31] ^ win[8][31] ^ win[13][31]};

  // Pad byte: marker first, then zeros, then the big-endian bit length
  assign len_shift = {msg_bytes, 3'b000} << {fill[2:0], 3'b000};
  always_comb begin
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (len_here && (fill >= LEN_FIRST)) begin
      pad_byte = len_shift[63:56];
    end else begin
      pad_byte = '0;
    end
  end

  // Chain update after a block
  always_comb begin
    for (int i = 0; i < DIGEST_WORDS; i++) begin
      chain_sum[i] = chain[i] + work[i];
    end
  end

  // Row of window cells, each fed by its right neighbor
  for (genvar gi = 0; gi < CELL_COUNT; gi++) begin : g_cell
    if (gi == CELL_COUNT - 1) begin : g_tail
      assign nbr[gi] = feed;
    end else begin : g_body
      assign nbr[gi] = win[gi + 1];
    end
    sha1_cell u_cell (
      .clk      (clk),
      .mode     (cell_mode),
      .nbr_word (nbr[gi]),
      .word     (win[gi])
    );
  end

  sha1_round u_round (
    .clk   (clk),
    .ctrl  (rctl),
    .chain (chain),
    .w     (win[0]),
    .work  (work)
  );

  sha1_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (emit_load),
    .digest       (chain_sum),
    .digest_ready (digest_ready),
    .digest_valid (digest_valid),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (action_t'(action) == ACT_FINISH) begin
            state_next = ST_PAD;
          end else if (fill == FILL_LAST) begin
            state_next = ST_ROUND;
          end
        end
      end
      ST_PAD: begin
        if (fill == FILL_LAST) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == ROUND_LAST) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        priority if (final_fold) begin
          state_next = emit_busy ? ST_FOLD : ST_IDLE;
        end else if (padding) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    item_ready = 1'b0;
    cell_mode  = CELL_HOLD;
    feed       = new_w;
    emit_load  = 1'b0;
    rctl.load  = (state_next == ST_ROUND) && (state != ST_ROUND);
    rctl.step  = (state == ST_ROUND);
    rctl.rnd   = rnd;
    unique case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (accept && (action_t'(action) == ACT_ABSORB)) begin
          cell_mode = CELL_BYTE;
          feed      = {data_byte, 24'h0};
        end
      end
      ST_PAD: begin
        cell_mode = CELL_BYTE;
        feed      = {pad_byte, 24'h0};
      end
      ST_ROUND: begin
        cell_mode = CELL_WORD;
      end
      ST_FOLD: begin
        emit_load = final_fold & ~emit_busy;
      end
      default: cell_mode = CELL_HOLD;
    endcase
  end

  // Counters, padding flags and chain words
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      msg_bytes <= '0;
      rnd       <= '0;
      pad_first <= 1'b0;
      len_here  <= 1'b0;
      padding   <= 1'b0;
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain[i] <= INIT_H[i];
      end
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          rnd <= '0;
          if (accept) begin
            if (action_t'(action) == ACT_ABSORB) begin
              fill      <= fill + 6'd1;
              msg_bytes <= msg_bytes + 61'd1;
            end else begin
              pad_first <= 1'b1;
              len_here  <= (fill <= FILL_LEN_LIMIT);
              padding   <= 1'b1;
            end
          end
        end
        ST_PAD: begin
          fill      <= fill + 6'd1;
          pad_first <= 1'b0;
          rnd       <= '0;
        end
        ST_ROUND: begin
          rnd <= rnd + 7'd1;
        end
        ST_FOLD: begin
          priority if (final_fold) begin
            if (!emit_busy) begin
              for (int i = 0; i < DIGEST_WORDS; i++) begin
                chain[i] <= INIT_H[i];
              end
              msg_bytes <= '0;
              padding   <= 1'b0;
              len_here  <= 1'b0;
            end
          end else if (padding) begin
            chain    <= chain_sum;
            len_here <= 1'b1;
          end else begin
            chain <= chain_sum;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  `SHA1_ASSERT_NXT(a_round_to_fold, (state == ST_ROUND) && (rnd == ROUND_LAST),
                   state == ST_FOLD, "last round must fold")
  `SHA1_ASSERT_IMP(a_block_full, (state == ST_ROUND) && (rnd == 7'd0),
                   fill == 6'd0, "block started before buffer full")
  `SHA1_ASSERT_NXT(a_digest_out, (state == ST_FOLD) && final_fold && !emit_busy,
                   digest_valid && (word_index == 3'd0), "digest not presented")
  `SHA1_ASSERT_IMP(a_pad_closed, state == ST_IDLE,
                   !padding && !pad_first, "padding left open in idle")

endmodule

`default_nettype wire

@@ tb/sha1_digest_checker.sv @@
// ----------------------------------------------------------------------------
// sha1_digest_checker
// Watches the item and digest channels of the SHA-1 hash unit, keeps its own
// running SHA-1 state per accepted beat and compares every digest beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         item_valid,
  input  wire         item_ready,
  input  wire         action,
  input  wire  [7:0]  data_byte,
  input  wire         digest_valid,
  input  wire         digest_ready,
  input  wire  [31:0] digest_word,
  input  wire  [2:0]  word_index,
  input  wire         last_word,
  output int          fail_count,
  output int          pending_words,
  output int          words_checked
);
  import sha1_pkg::*;

  localparam logic [31:0] K_CHOOSE   = 32'h5A827999;
  localparam logic [31:0] K_PARITY_A = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJORITY = 32'h8F1BBCDC;
  localparam logic [31:0] K_PARITY_B = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0]  chain_h [5];
  logic [7:0]   block_bytes [64];
  int           fill;
  logic [60:0]  msg_len;
  digest_beat_t digest_fifo [$];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // Start a fresh message from the standard initial chain.
  task automatic restart_message();
    chain_h[0] = 32'h67452301;
    chain_h[1] = 32'hEFCDAB89;
    chain_h[2] = 32'h98BADCFE;
    chain_h[3] = 32'h10325476;
    chain_h[4] = 32'hC3D2E1F0;
    fill = 0;
    msg_len = '0;
  endtask

  // Run the 80 rounds over the buffered block and fold into the chain.
  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w[r % 16] = rotl(w[(r - 3) % 16] ^ w[(r - 8) % 16] ^ w[(r - 14) % 16] ^ w[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_CHOOSE;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_PARITY_A;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJORITY;
      end else begin
        f = b ^ c ^ d;
        k = K_PARITY_B;
      end
      t = rotl(a, 5) + f + e + w[r % 16] + k;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    block_bytes[fill] = b;
    fill++;
    msg_len++;
    if (fill == 64) begin
      compress_block();
      fill = 0;
    end
  endtask

  // Pad, append the bit length, compress and queue the five digest beats.
  task automatic finish_message();
    logic [63:0]  bit_len;
    digest_beat_t beat;
    block_bytes[fill] = PAD_BYTE;
    fill++;
    if (fill > 56) begin
      for (int i = fill; i < 64; i++) block_bytes[i] = 8'h00;
      compress_block();
      fill = 0;
    end
    for (int i = fill; i < 56; i++) block_bytes[i] = 8'h00;
    bit_len = {msg_len, 3'b000};
    for (int i = 0; i < 8; i++) block_bytes[63 - i] = bit_len[8*i +: 8];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      beat.word  = chain_h[i];
      beat.index = 3'(i);
      beat.last  = (i == 4);
      digest_fifo.push_back(beat);
    end
    restart_message();
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns  digest mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Compare one digest beat against the oldest pending word.
  task automatic check_beat();
    digest_beat_t want;
    words_checked++;
    if (digest_fifo.size() == 0) begin
      report_mismatch($sformatf("unexpected beat word=%h index=%0d", digest_word, word_index));
    end else begin
      want = digest_fifo.pop_front();
      if (digest_word !== want.word) begin
        report_mismatch($sformatf("word got %h want %h (index %0d)",
                                  digest_word, want.word, want.index));
      end
      if (word_index !== want.index) begin
        report_mismatch($sformatf("word_index got %0d want %0d", word_index, want.index));
      end
      if (last_word !== want.last) begin
        report_mismatch($sformatf("last_word got %b want %b (index %0d)",
                                  last_word, want.last, want.index));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart_message();
      digest_fifo.delete();
      pending_words = 0;
    end else begin
      if (digest_valid && digest_ready) begin
        check_beat();
      end
      if (item_valid && item_ready) begin
        if (action == ACT_FINISH) begin
          finish_message();
        end else begin
          absorb_byte(data_byte);
        end
      end
      pending_words = digest_fifo.size();
    end
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Byte-stream stimulus for the SHA-1 hash unit: known short messages, padding
// boundary lengths, random and broken messages, with random gaps on both
// channels and one long digest back-pressure window. The checker judges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import sha1_pkg::*;

  localparam int HOLD_CYCLES  = 1000;
  localparam int DRAIN_CYCLES = 400;
  localparam int RANDOM_ITEMS = 100;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  action_t     action;
  logic [7:0]  data_byte;
  logic        digest_valid;
  logic        digest_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  int fail_count;
  int pending_words;
  int words_checked;
  int hold_requests;
  int holds_done;
  int items_sent;
  int bytes_sent;
  int finishes_sent;
  bit steady_sender;

  sha1_hash_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .action       (action),
    .data_byte    (data_byte),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  sha1_digest_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .action        (action),
    .data_byte     (data_byte),
    .digest_valid  (digest_valid),
    .digest_ready  (digest_ready),
    .digest_word   (digest_word),
    .word_index    (word_index),
    .last_word     (last_word),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Offer one beat and hold it until accepted.
  task automatic send_item(input action_t act, input logic [7:0] b);
    int gap;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    action     <= act;
    data_byte  <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    items_sent++;
    if (act == ACT_FINISH) finishes_sent++;
    else bytes_sent++;
  endtask

  // A message of len random bytes closed by a finish; broken ones may finish early.
  task automatic send_message(input int len, input bit broken);
    action_t act;
    for (int i = 0; i < len; i++) begin
      act = (broken && $urandom_range(0, 7) == 0) ? ACT_FINISH : ACT_ABSORB;
      send_item(act, 8'($urandom_range(0, 255)));
    end
    send_item(ACT_FINISH, 8'($urandom_range(0, 255)));
  endtask

  // Digest side: random ready with stalls, plus the requested long hold-off.
  initial begin
    int stall;
    holds_done = 0;
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        digest_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      digest_ready <= 1'b1;
      repeat ($urandom_range(0, 9) == 0 ? 200 : $urandom_range(1, 24)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        digest_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin
    int boundary_len [4];
    int next_boundary;
    int directed_items;
    boundary_len  = '{55, 56, 63, 64};
    next_boundary = 0;
    hold_requests = 0;
    items_sent    = 0;
    bytes_sent    = 0;
    finishes_sent = 0;
    steady_sender = 1'b0;
    rst        <= 1'b1;
    item_valid <= 1'b0;
    action     <= ACT_ABSORB;
    data_byte  <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty message, then a finish right after a finish.
    send_item(ACT_FINISH, 8'hFF);
    send_item(ACT_FINISH, 8'h00);
    // "abc"
    send_item(ACT_ABSORB, 8'h61);
    send_item(ACT_ABSORB, 8'h62);
    send_item(ACT_ABSORB, 8'h63);
    send_item(ACT_FINISH, 8'h5A);
    // Byte extremes and the pad value as data.
    send_item(ACT_ABSORB, 8'h00);
    send_item(ACT_ABSORB, 8'hFF);
    send_item(ACT_ABSORB, 8'h80);
    send_item(ACT_ABSORB, 8'h7F);
    send_item(ACT_FINISH, 8'hA5);
    directed_items = items_sent;

    // Back-pressure: several short messages while the digest side is held off.
    hold_requests++;
    steady_sender = 1'b1;
    for (int m = 0; m < 5; m++) send_message(2, 1'b0);

    // Random messages, with the pad split lengths and a full block mixed in.
    while (items_sent < directed_items + RANDOM_ITEMS || next_boundary < 4
           || finishes_sent < 20) begin
      steady_sender = ($urandom_range(0, 3) == 0);
      if (next_boundary < 4 && $urandom_range(0, 2) == 0) begin
        send_message(boundary_len[next_boundary], 1'b0);
        next_boundary++;
      end else begin
        send_message($urandom_range(0, 12), $urandom_range(0, 4) == 0);
      end
    end
    item_valid <= 1'b0;

    // Drain: let the checker see the last beat, then wait out stragglers.
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d message bytes over %0d finishes, pad split lengths 55/56/63/64",
             bytes_sent, finishes_sent);
    $display("checked %0d digest words, one digest hold-off of %0d cycles",
             words_checked, HOLD_CYCLES);
    if (fail_count == 0 && pending_words == 0) begin
      $display("[sha1_hash_unit] OK");
    end else begin
      $display("[sha1_hash_unit] ERROR");
    end
    $finish;
  end

  // Hard stop if the unit hangs.
  initial begin
    #5_000_000;
    $display("timeout with %0d digest words outstanding", pending_words);
    $display("[sha1_hash_unit] ERROR");
    $finish;
  end

endmodule
